// ===== hw/rtl/icmp_echo_reply_rewriter_core_macros.svh =====
// assertion macros for the echo responder checker
`ifndef ICMP_ECHO_REPLY_REWRITER_CORE_MACROS_SVH
`define ICMP_ECHO_REPLY_REWRITER_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define ICMP_ERW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("icmp_erw check failed: %m");

// property checked at every clock edge, reset included
`define ICMP_ERW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("icmp_erw check failed: %m");

`endif

// ===== hw/rtl/icmp_erw_pkg.sv =====
package icmp_erw_pkg;

  // header geometry
  localparam int unsigned HdrLen    = 42;
  localparam int unsigned CntW      = 6;
  localparam int unsigned EthLen    = 14;
  localparam int unsigned IpEnd     = 34;

  // byte offsets inside the held header
  localparam int unsigned EtypeHiIdx = 12;
  localparam int unsigned EtypeLoIdx = 13;
  localparam int unsigned ProtoIdx   = 23;
  localparam int unsigned TypeIdx    = 34;
  localparam int unsigned CsumHiIdx  = 36;
  localparam int unsigned CsumLoIdx  = 37;
  localparam int unsigned MacDstIdx  = 0;
  localparam int unsigned MacSrcIdx  = 6;
  localparam int unsigned MacLen     = 6;
  localparam int unsigned IpSrcIdx   = 26;
  localparam int unsigned IpDstIdx   = 30;
  localparam int unsigned IpAddrLen  = 4;

  // protocol values
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoIcmp     = 8'd1;
  localparam logic [7:0]  IcmpEchoReq   = 8'd8;
  localparam logic [7:0]  IcmpEchoReply = 8'd0;
  localparam logic [15:0] CsumAdj       = 16'h0800;

  typedef logic [HdrLen-1:0][7:0] hdr_t;

  typedef enum logic [1:0] {
    VerdictTx   = 2'd0,
    VerdictPass = 2'd1,
    VerdictDrop = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    StCapture,
    StDecide,
    StAlign,
    StEmit,
    StPass
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/icmp_echo_reply_rewriter_core.sv =====
// icmp echo responder
// input channel: in_valid_i/in_ready_o carry one frame byte per word, with
// frame_end_i on the last byte. output channel: out_valid_o/out_ready_i carry
// out_byte_o, out_end_o and verdict_o (0 transmit back, 1 pass, 2 drop).
// the first 42 bytes of a frame are shifted into a chain of 42 byte cells.
// when the 42nd byte or an earlier frame end arrives, a decide state sets the
// verdict and rewrites an echo request in place, then the chain shifts the
// held bytes out one word per cycle while the receiver keeps up. a short
// frame first shifts through an align state to bring its first byte to the
// head of the chain. input is not taken during decide, align and the burst.
// bytes after the header stream through one output register at one word per
// cycle while the receiver keeps up.
// a stalled receiver holds the output register; the chain and the input
// wait for it. reset empties the output and starts a new frame.
module icmp_echo_reply_rewriter_core
  import icmp_erw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] frame_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_end_o,
  output logic [1:0] verdict_o
);

  state_e            state_d, state_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic [CntW-1:0]   len_d, len_q;
  logic [CntW-1:0]   emit_d, emit_q;
  logic              end_d, end_q;
  verdict_e          vrd_d, vrd_q, vrd_new;
  logic [7:0]        etype_hi_q, etype_lo_q, proto_q, type_q;
  logic              out_valid_d, out_valid_q;
  logic [7:0]        out_byte_d, out_byte_q;
  logic              out_end_d, out_end_q;
  logic [1:0]        out_vrd_d, out_vrd_q;
  logic              out_free, in_acc, out_load, emit_last, hdr_last;
  cell_ctrl_t        cell_ctrl;
  hdr_t              hdr, hdr_rw;

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_acc    = in_valid_i && in_ready_o;
  assign emit_last = (emit_q + CntW'(1)) == len_q;
  assign hdr_last  = frame_end_i || (cnt_q == CntW'(HdrLen - 1));

  // verdict from the captured fields and the held length
  always_comb begin
    if (len_q < CntW'(EthLen)) begin
      vrd_new = VerdictDrop;
    end else if ({etype_hi_q, etype_lo_q} != EtherTypeIpv4) begin
      vrd_new = VerdictPass;
    end else if (len_q < CntW'(IpEnd)) begin
      vrd_new = VerdictDrop;
    end else if (proto_q != ProtoIcmp) begin
      vrd_new = VerdictPass;
    end else if (len_q < CntW'(HdrLen)) begin
      vrd_new = VerdictDrop;
    end else if (type_q != IcmpEchoReq) begin
      vrd_new = VerdictPass;
    end else begin
      vrd_new = VerdictTx;
    end
  end

  // header cell chain, byte 0 at the head
  for (genvar g = 0; g < HdrLen; g++) begin : gen_cell
    logic [7:0] nbr;
    if (g == HdrLen - 1) begin : gen_tail
      assign nbr = frame_byte_i;
    end else begin : gen_mid
      assign nbr = hdr[g + 1];
    end
    icmp_erw_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .nbr_i  (nbr),
      .alt_i  (hdr_rw[g]),
      .byte_o (hdr[g])
    );
  end

  icmp_erw_rewrite u_rewrite (
    .hdr_i (hdr),
    .hdr_o (hdr_rw)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StCapture: begin
        if (in_acc && hdr_last) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        state_d = (len_q == CntW'(HdrLen)) ? StEmit : StAlign;
      end
      StAlign: begin
        if (cnt_q == CntW'(HdrLen - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free && emit_last) begin
          state_d = end_q ? StCapture : StPass;
        end
      end
      StPass: begin
        if (in_acc && frame_end_i) begin
          state_d = StCapture;
        end
      end
      default: state_d = StCapture;
    endcase
  end

  // handshake and chain control
  always_comb begin
    in_ready_o      = 1'b0;
    out_load        = 1'b0;
    cell_ctrl.shift = 1'b0;
    cell_ctrl.load  = 1'b0;
    case (state_q)
      StCapture: begin
        in_ready_o      = 1'b1;
        cell_ctrl.shift = in_valid_i;
      end
      StDecide: begin
        cell_ctrl.load = (vrd_new == VerdictTx);
      end
      StAlign: begin
        cell_ctrl.shift = 1'b1;
      end
      StEmit: begin
        out_load        = out_free;
        cell_ctrl.shift = out_free;
      end
      StPass: begin
        in_ready_o = out_free;
        out_load   = in_valid_i && out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // counters and frame status
  always_comb begin
    cnt_d  = cnt_q;
    len_d  = len_q;
    emit_d = emit_q;
    end_d  = end_q;
    vrd_d  = vrd_q;
    case (state_q)
      StCapture: begin
        if (in_acc) begin
          cnt_d = cnt_q + CntW'(1);
          if (hdr_last) begin
            len_d = cnt_q + CntW'(1);
            end_d = frame_end_i;
          end
        end
      end
      StDecide: begin
        vrd_d  = vrd_new;
        emit_d = '0;
      end
      StAlign: begin
        cnt_d = cnt_q + CntW'(1);
      end
      StEmit: begin
        if (out_free) begin
          emit_d = emit_q + CntW'(1);
          if (emit_last) begin
            cnt_d = '0;
          end
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // output register, loaded from the chain head or the input
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    out_vrd_d   = out_vrd_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_vrd_d   = vrd_q;
      if (state_q == StEmit) begin
        out_byte_d = hdr[0];
        out_end_d  = end_q && emit_last;
      end else begin
        out_byte_d = frame_byte_i;
        out_end_d  = frame_end_i;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StCapture;
      cnt_q       <= '0;
      len_q       <= '0;
      emit_q      <= '0;
      end_q       <= 1'b0;
      vrd_q       <= VerdictTx;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      emit_q      <= emit_d;
      end_q       <= end_d;
      vrd_q       <= vrd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers and captured header fields
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
    out_vrd_q  <= out_vrd_d;
    if (state_q == StCapture && in_acc) begin
      if (cnt_q == CntW'(EtypeHiIdx)) etype_hi_q <= frame_byte_i;
      if (cnt_q == CntW'(EtypeLoIdx)) etype_lo_q <= frame_byte_i;
      if (cnt_q == CntW'(ProtoIdx))   proto_q    <= frame_byte_i;
      if (cnt_q == CntW'(TypeIdx))    type_q     <= frame_byte_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_end_o   = out_end_q;
  assign verdict_o   = out_vrd_q;

endmodule

// ===== hw/rtl/icmp_erw_cell.sv =====
module icmp_erw_cell
  import icmp_erw_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] nbr_i,
  input  logic [7:0] alt_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_d, byte_q;

  // take the neighbor's byte on a shift, the rewritten byte on a load
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = nbr_i;
    end else if (ctrl_i.load) begin
      byte_d = alt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// ===== hw/rtl/icmp_erw_rewrite.sv =====
module icmp_erw_rewrite
  import icmp_erw_pkg::*;
(
  input  hdr_t hdr_i,
  output hdr_t hdr_o
);

  logic [16:0] sum;
  logic [15:0] csum;

  // ones-complement add of the type change, end-around carry
  assign sum  = {1'b0, hdr_i[CsumHiIdx], hdr_i[CsumLoIdx]} + {1'b0, CsumAdj};
  assign csum = sum[15:0] + {15'b0, sum[16]};

  // swap addresses, turn request into reply, patch checksum
  always_comb begin
    hdr_o = hdr_i;
    for (int i = 0; i < MacLen; i++) begin
      hdr_o[MacDstIdx + i] = hdr_i[MacSrcIdx + i];
      hdr_o[MacSrcIdx + i] = hdr_i[MacDstIdx + i];
    end
    for (int i = 0; i < IpAddrLen; i++) begin
      hdr_o[IpSrcIdx + i] = hdr_i[IpDstIdx + i];
      hdr_o[IpDstIdx + i] = hdr_i[IpSrcIdx + i];
    end
    hdr_o[TypeIdx]   = IcmpEchoReply;
    hdr_o[CsumHiIdx] = csum[15:8];
    hdr_o[CsumLoIdx] = csum[7:0];
  end

endmodule

// ===== hw/rtl/icmp_erw_checker.sv =====
`include "icmp_echo_reply_rewriter_core_macros.svh"

module icmp_erw_checker
  import icmp_erw_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] frame_byte_i,
  input logic       frame_end_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_end_o,
  input logic [1:0] verdict_o
);

  logic out_stall, in_acc, vrd_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_acc    = in_valid_i && in_ready_o;
  assign vrd_ok    = (verdict_o == VerdictTx) || (verdict_o == VerdictPass) ||
                     (verdict_o == VerdictDrop);

  // a stalled output word holds
  `ICMP_ERW_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable({out_byte_o, out_end_o, verdict_o}))

  // every output word carries a known verdict
  `ICMP_ERW_ASSERT(a_verdict_known, out_valid_o |-> vrd_ok)

  // handshake outputs are always known once out of reset
  `ICMP_ERW_ASSERT(a_hs_known, !$isunknown({in_ready_o, out_valid_o}))

  // an accepted input word has a known payload
  `ICMP_ERW_ASSERT(a_in_known, in_acc |-> !$isunknown({frame_byte_i, frame_end_i}))

  // no output word right after reset
  `ICMP_ERW_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o)

endmodule

bind icmp_echo_reply_rewriter_core icmp_erw_checker u_icmp_erw_checker (.*);
